### rtl/png_carve_packet_classifier_assert.svh
// Assertion macros for the PNG carve packet classifier.
// Used by pcc_front, pcc_queue and pcc_back; expects clk and rst in scope.
`ifndef PNG_CARVE_PACKET_CLASSIFIER_ASSERT_SVH
`define PNG_CARVE_PACKET_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCC_ASSERT_ALWAYS(label, c) \
  label: assert property (@(posedge clk) disable iff (rst) (c)) \
    else $error("pcc assertion failed");
`define PCC_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pcc assertion failed");
`define PCC_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_ALWAYS(label, c)
`define PCC_ASSERT_IMPL(label, a, c)
`define PCC_ASSERT_NEXT(label, a, c)
`endif
`endif

### rtl/pcc_pkg.sv
// Shared types, constants and signature tables of the PNG carve classifier.
// No dependencies.
package pcc_pkg;

  localparam int ETH_HDR_BYTES = 14;
  localparam int MIN_HDR_BYTES = 20;
  localparam int ACK_FIRST = 8;
  localparam int ACK_LAST = 11;
  localparam int TCP_OFF_BYTE = 12;
  localparam int PNG_SIG_LEN = 4;
  localparam int HTTP_SIG_LEN = 6;
  localparam int TAIL_WINDOWS = 5;

  localparam logic [7:0] IHL_MASK = 8'h0f;
  localparam logic [7:0] TCP_OFF_MASK = 8'hf0;
  localparam logic [31:0] IEND_WORD = 32'h49454E44;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_BAD_IP  = 3'd1,
    ST_BAD_TCP = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_CARVE   = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        sigs_seen;
    logic        iend;
    logic [31:0] ack;
    logic [11:0] len;
    logic [11:0] pay;
    logic [11:0] png_offset;
  } frame_summary_t;

  function automatic logic [7:0] png_sig_byte(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h89;
      2'd1: r = 8'h50;
      2'd2: r = 8'h4E;
      2'd3: r = 8'h47;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] http_sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = 8'h48;
      3'd1: r = 8'h54;
      3'd2: r = 8'h54;
      3'd3: r = 8'h50;
      3'd4: r = 8'h2f;
      3'd5: r = 8'h31;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### rtl/pcc_in_if.sv
// Byte input channel of the PNG carve classifier: one frame byte per item.
// No dependencies.
interface pcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/pcc_out_if.sv
// Result channel of the PNG carve classifier: one descriptor per frame.
// No dependencies.
interface pcc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [10:0] carve_start;
  logic [11:0] carve_length;
  logic        session_opened;
  logic        image_end;
  logic [31:0] session_id;

  modport source (
    output valid, output status, output carve_start, output carve_length,
    output session_opened, output image_end, output session_id, input ready
  );
  modport sink (
    input valid, input status, input carve_start, input carve_length,
    input session_opened, input image_end, input session_id, output ready
  );
endinterface

### rtl/pcc_front.sv
// Front end: parses header lengths and ack, runs signature matchers per byte,
// and pushes a frame summary at the last byte. Depends on pcc_pkg, pcc_in_if.
`include "png_carve_packet_classifier_assert.svh"
module pcc_front #(
  parameter int MAX_FRAME = 2048
) (
  input  logic                    clk,
  input  logic                    rst,
  pcc_in_if.sink                  frame,
  input  logic                    full,
  output logic                    push,
  output pcc_pkg::frame_summary_t summary
);

  localparam int PW = $clog2(MAX_FRAME + 1);
  localparam int CW = (PW > 8) ? PW : 8;

  logic [PW-1:0] byte_position, byte_position_next;
  logic [5:0]    ip_header_bytes, ip_header_bytes_next;
  logic [5:0]    tcp_header_bytes, tcp_header_bytes_next;
  logic [31:0]   frame_ack, frame_ack_next;
  logic [2:0]    png_match_progress, png_match_progress_next;
  logic          png_seen, png_seen_next;
  logic [PW-1:0] png_offset, png_offset_next;
  logic [2:0]    http_match_progress, http_match_progress_next;
  logic          http_seen, http_seen_next;
  logic [63:0]   tail_window, tail_window_next;
  logic          oversize_flag, oversize_flag_next;

  logic          accept;
  logic          take;
  logic [7:0]    b;
  logic [CW-1:0] pos_w, hdr_base, rel;
  logic          in_tcp, payload;
  logic [2:0]    png_step, http_step;
  logic [CW-1:0] len_c, tcp_byte_c, pay_c;
  logic          iend_hit;

  assign b = frame.data_byte;
  assign frame.ready = !full;
  assign accept = frame.valid && frame.ready;
  assign push = accept && frame.last_byte;
  assign take = byte_position < PW'(MAX_FRAME);

  assign pos_w = CW'(byte_position);
  assign hdr_base = CW'(pcc_pkg::ETH_HDR_BYTES) + CW'(ip_header_bytes);
  assign rel = pos_w - hdr_base;
  assign in_tcp = (ip_header_bytes >= 6'(pcc_pkg::MIN_HDR_BYTES)) && (pos_w >= hdr_base);
  assign payload = in_tcp && (tcp_header_bytes >= 6'(pcc_pkg::MIN_HDR_BYTES)) &&
                   (rel >= CW'(tcp_header_bytes));

  always_comb begin
    byte_position_next = byte_position;
    ip_header_bytes_next = ip_header_bytes;
    tcp_header_bytes_next = tcp_header_bytes;
    frame_ack_next = frame_ack;
    png_match_progress_next = png_match_progress;
    png_seen_next = png_seen;
    png_offset_next = png_offset;
    http_match_progress_next = http_match_progress;
    http_seen_next = http_seen;
    tail_window_next = tail_window;
    oversize_flag_next = oversize_flag;
    png_step = 3'd0;
    http_step = 3'd0;
    if (take) begin
      byte_position_next = byte_position + PW'(1);
      tail_window_next = {tail_window[55:0], b};
      if (pos_w == CW'(pcc_pkg::ETH_HDR_BYTES)) begin
        ip_header_bytes_next = {b[3:0] & pcc_pkg::IHL_MASK[3:0], 2'b00};
      end
      if (in_tcp && rel >= CW'(pcc_pkg::ACK_FIRST) && rel <= CW'(pcc_pkg::ACK_LAST)) begin
        frame_ack_next = {frame_ack[23:0], b};
      end
      if (in_tcp && rel == CW'(pcc_pkg::TCP_OFF_BYTE)) begin
        tcp_header_bytes_next = {b[7:4] & pcc_pkg::TCP_OFF_MASK[7:4], 2'b00};
      end
      if (payload && !png_seen) begin
        if (b == pcc_pkg::png_sig_byte(png_match_progress[1:0])) begin
          png_step = png_match_progress + 3'd1;
        end else begin
          png_step = {2'b00, b == pcc_pkg::png_sig_byte(2'd0)};
        end
        if (png_step == 3'(pcc_pkg::PNG_SIG_LEN)) begin
          png_seen_next = 1'b1;
          png_offset_next = byte_position - PW'(pcc_pkg::PNG_SIG_LEN - 1);
          png_match_progress_next = 3'd0;
        end else begin
          png_match_progress_next = png_step;
        end
      end
      if (payload && !http_seen) begin
        if (http_match_progress < 3'(pcc_pkg::HTTP_SIG_LEN) &&
            b == pcc_pkg::http_sig_byte(http_match_progress)) begin
          http_step = http_match_progress + 3'd1;
        end else begin
          http_step = {2'b00, b == pcc_pkg::http_sig_byte(3'd0)};
        end
        if (http_step == 3'(pcc_pkg::HTTP_SIG_LEN)) begin
          http_seen_next = 1'b1;
          http_match_progress_next = 3'd0;
        end else begin
          http_match_progress_next = http_step;
        end
      end
    end else begin
      oversize_flag_next = 1'b1;
    end
  end

  always_comb begin
    iend_hit = 1'b0;
    for (int i = 0; i < pcc_pkg::TAIL_WINDOWS; i++) begin
      if (tail_window_next[8*i +: 32] == pcc_pkg::IEND_WORD) begin
        iend_hit = 1'b1;
      end
    end
  end

  assign len_c = CW'(byte_position_next);
  assign tcp_byte_c = CW'(pcc_pkg::ETH_HDR_BYTES) + CW'(ip_header_bytes_next) +
                      CW'(pcc_pkg::TCP_OFF_BYTE);
  assign pay_c = CW'(pcc_pkg::ETH_HDR_BYTES) + CW'(ip_header_bytes_next) +
                 CW'(tcp_header_bytes_next);

  always_comb begin
    summary.sigs_seen = png_seen_next && http_seen_next;
    summary.iend = iend_hit;
    summary.ack = frame_ack_next;
    summary.len = 12'(byte_position_next);
    summary.pay = 12'(pay_c);
    summary.png_offset = 12'(png_offset_next);
    priority if (oversize_flag_next || len_c <= CW'(pcc_pkg::ETH_HDR_BYTES)) begin
      summary.status = pcc_pkg::ST_TRUNC;
    end else if (ip_header_bytes_next < 6'(pcc_pkg::MIN_HDR_BYTES)) begin
      summary.status = pcc_pkg::ST_BAD_IP;
    end else if (len_c <= tcp_byte_c) begin
      summary.status = pcc_pkg::ST_TRUNC;
    end else if (tcp_header_bytes_next < 6'(pcc_pkg::MIN_HDR_BYTES)) begin
      summary.status = pcc_pkg::ST_BAD_TCP;
    end else if (len_c < pay_c) begin
      summary.status = pcc_pkg::ST_TRUNC;
    end else begin
      summary.status = pcc_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position <= '0;
      ip_header_bytes <= '0;
      tcp_header_bytes <= '0;
      frame_ack <= '0;
      png_match_progress <= '0;
      png_seen <= 1'b0;
      png_offset <= '0;
      http_match_progress <= '0;
      http_seen <= 1'b0;
      tail_window <= '0;
      oversize_flag <= 1'b0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      ip_header_bytes <= ip_header_bytes_next;
      tcp_header_bytes <= tcp_header_bytes_next;
      frame_ack <= frame_ack_next;
      png_match_progress <= png_match_progress_next;
      png_seen <= png_seen_next;
      png_offset <= png_offset_next;
      http_match_progress <= http_match_progress_next;
      http_seen <= http_seen_next;
      tail_window <= tail_window_next;
      oversize_flag <= oversize_flag_next;
    end
  end

  `PCC_ASSERT_NEXT(a_front_clear_after_push, push, byte_position == '0 && !png_seen)

endmodule

### rtl/pcc_queue.sv
// Short queue of frame summaries between the front and back ends.
// Depends on pcc_pkg.
`include "png_carve_packet_classifier_assert.svh"
module pcc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pcc_pkg::frame_summary_t push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    q_valid,
  output pcc_pkg::frame_summary_t q_data
);

  pcc_pkg::frame_summary_t entries [pcc_pkg::QUEUE_DEPTH];
  logic [pcc_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [pcc_pkg::QCNT_W-1:0] count;

  assign full = count == pcc_pkg::QCNT_W'(pcc_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data = entries[rd_ptr];

  function automatic logic [pcc_pkg::QPTR_W-1:0] advance(input logic [pcc_pkg::QPTR_W-1:0] p);
    logic [pcc_pkg::QPTR_W-1:0] r;
    if (p == pcc_pkg::QPTR_W'(pcc_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + pcc_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + pcc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - pcc_pkg::QCNT_W'(1);
      end
    end
  end

  `PCC_ASSERT_ALWAYS(a_queue_bound, count <= pcc_pkg::QCNT_W'(pcc_pkg::QUEUE_DEPTH))
  `PCC_ASSERT_IMPL(a_queue_pop_nonempty, pop, count != '0)

endmodule

### rtl/pcc_back.sv
// Back end: session tracking, carve decision and the result output register.
// Depends on pcc_pkg, pcc_out_if.
`include "png_carve_packet_classifier_assert.svh"
module pcc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  pcc_pkg::frame_summary_t q_data,
  output logic                    pop,
  pcc_out_if.source               result
);

  logic [31:0] session_ack;
  logic [31:0] image_id;
  logic [31:0] frame_counter;

  logic        hdr_ok, open, carve, close;
  logic [31:0] counter_step, sess_eff, id_eff;
  logic [11:0] start;

  assign pop = q_valid && (!result.valid || result.ready);
  assign counter_step = frame_counter + 32'd1;
  assign hdr_ok = q_data.status == pcc_pkg::ST_NONE;
  assign open = hdr_ok && session_ack == '0 && q_data.sigs_seen && q_data.ack != '0;
  assign sess_eff = open ? q_data.ack : session_ack;
  assign id_eff = open ? counter_step + q_data.ack : image_id;
  assign carve = hdr_ok && sess_eff != '0 && q_data.ack == sess_eff;
  assign close = carve && q_data.iend;
  assign start = open ? q_data.png_offset : q_data.pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      session_ack <= '0;
      image_id <= '0;
      frame_counter <= 32'd1;
    end else if (pop) begin
      frame_counter <= counter_step;
      if (close) begin
        session_ack <= '0;
        image_id <= '0;
      end else if (open) begin
        session_ack <= q_data.ack;
        image_id <= id_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.status <= carve ? pcc_pkg::ST_CARVE : q_data.status;
      result.carve_start <= carve ? start[10:0] : '0;
      result.carve_length <= carve ? q_data.len - start : '0;
      result.session_opened <= carve && open;
      result.image_end <= close;
      result.session_id <= carve ? id_eff : '0;
    end
  end

  `PCC_ASSERT_NEXT(a_back_pop_loads, pop, result.valid)
  `PCC_ASSERT_NEXT(a_back_close_idles, pop && close, session_ack == '0 && image_id == '0)

endmodule

### rtl/png_carve_packet_classifier.sv
// PNG carve packet classifier, top level.
// Takes captured Ethernet/IPv4/TCP frames on the frame channel, one byte per
// item with last_byte marking the final byte, and returns one descriptor per
// frame on the result channel: status, carve offset and length, session flags
// and session id.
// Throughput: one byte per cycle while frame.ready is high; the per-byte header
// parse and signature matchers in pcc_front handle each byte as it is taken,
// and a frame of any length can follow the previous one directly.
// The edge that takes the last byte writes the frame summary into the queue;
// the back end pops it into its output register as soon as that register is
// empty or being read, which makes the descriptor valid.
// A two-entry summary queue sits between front and back, and the output
// register holds a third descriptor; when the result receiver stalls and the
// queue is full, frame.ready drops for every byte until the back end pops.
// Reset (rst, synchronous) clears the parser, the queue, the output register,
// closes any session and sets the frame counter to one.
// Depends on pcc_pkg, pcc_in_if, pcc_out_if, pcc_front, pcc_queue, pcc_back.
module png_carve_packet_classifier #(
  parameter int MAX_FRAME = 2048
) (
  input  logic       clk,
  input  logic       rst,
  pcc_in_if.sink     frame,
  pcc_out_if.source  result
);

  logic                    push, full, pop, q_valid;
  pcc_pkg::frame_summary_t push_data, q_data;

  pcc_front #(
    .MAX_FRAME(MAX_FRAME)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .full    (full),
    .push    (push),
    .summary (push_data)
  );

  pcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  pcc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .result  (result)
  );

endmodule
